// ----- hw/rtl/psa_pkg.sv -----
// ----------------------------------------------------------------------------
// psa_pkg: shared types, constants and helpers
// Payload structs, register indexes, multiplier operand types and the small
// saturation and scroll-remainder functions used by the pointer block.
// ----------------------------------------------------------------------------
`default_nettype none

package psa_pkg;

  localparam int unsigned MAC_A_W    = 32;
  localparam int unsigned MAC_B_W    = 17;
  localparam int unsigned MAC_W      = 49;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned ROOT_W     = 16;
  localparam int unsigned ROOT_STEPS = 16;
  localparam int unsigned ROOT_CNT_W = $clog2(ROOT_STEPS + 1);

  localparam logic [2:0]         SHIFT_RESET    = 3'd3;
  localparam logic [7:0]         MIN_RESET      = 8'd2;
  localparam logic [7:0]         MAX_RESET      = 8'd32;
  localparam logic [7:0]         GROWTH_RESET   = 8'd32;
  localparam logic [15:0]        MOMENTUM_RESET = 16'd655;
  localparam logic [MAC_A_W-1:0] AVG_RESET      = 32'h0002_0000;
  localparam logic [MAC_B_W-1:0] ONE_Q16        = 17'h1_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHIFT_H  = 3'd0,
    REG_SHIFT_V  = 3'd1,
    REG_MIN      = 3'd2,
    REG_MAX      = 3'd3,
    REG_GROWTH   = 3'd4,
    REG_MOMENTUM = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    MAC_HOLD = 3'd0,
    MAC_SQX  = 3'd1,
    MAC_SQY  = 3'd2,
    MAC_FACT = 3'd3,
    MAC_MOM  = 3'd4,
    MAC_KEEP = 3'd5,
    MAC_SCX  = 3'd6,
    MAC_SCY  = 3'd7
  } mac_op_e;

  typedef struct packed {
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;
    logic signed [7:0] wheel_h_in;
    logic signed [7:0] wheel_v_in;
    logic              scroll_mode;
  } psa_in_t;

  typedef struct packed {
    logic signed [7:0] out_x;
    logic signed [7:0] out_y;
    logic signed [7:0] out_wheel_h;
    logic signed [7:0] out_wheel_v;
  } psa_out_t;

  typedef struct packed {
    logic               en;
    logic [MAC_A_W-1:0] a;
    logic [MAC_B_W-1:0] b;
    logic [MAC_W-1:0]   c;
  } mac_opnd_t;

  typedef struct packed {
    logic    idle;
    mac_op_e mac_op;
    logic    root_start;
    logic    avg_load;
    logic    x_load;
    logic    scroll_load;
    logic    out_load;
  } psa_ctrl_t;

  typedef struct packed {
    logic in_accept;
    logic scroll;
    logic root_last;
    logic out_free;
  } psa_stat_t;

  typedef struct packed {
    logic signed [8:0] whole;
    logic [7:0]        rest;
  } scroll_res_t;

  function automatic logic [8:0] abs8(logic [7:0] v);
    logic [8:0] w;
    w = {v[7], v};
    return v[7] ? 9'(~w + 9'd1) : w;
  endfunction

  function automatic logic [7:0] sat9(logic signed [8:0] v);
    if (v > 9'sd127) begin
      return 8'h7f;
    end else if (v < -9'sd128) begin
      return 8'h80;
    end
    return v[7:0];
  endfunction

  // magnitude q with sign neg, clipped to int8
  function automatic logic [7:0] sat_mag(logic [23:0] q, logic neg);
    if (neg) begin
      return (q >= 24'd128) ? 8'h80 : 8'(~q[7:0] + 8'd1);
    end
    return (q >= 24'd127) ? 8'h7f : q[7:0];
  endfunction

  // remainder in 1/128 units; integer part truncated toward zero
  function automatic scroll_res_t scroll_axis(logic [7:0] rest, logic [7:0] move,
                                              logic [2:0] shift);
    logic signed [15:0] mv;
    logic signed [15:0] sum;
    logic signed [15:0] adj;
    logic signed [15:0] wx;
    logic signed [15:0] frac;
    scroll_res_t        r;
    mv      = signed'({{8{move[7]}}, move}) <<< (3'd7 - shift);
    sum     = mv + signed'({{8{rest[7]}}, rest});
    adj     = sum[15] ? sum + 16'sd127 : sum;
    r.whole = 9'(adj >>> 7);
    wx      = {{7{r.whole[8]}}, r.whole};
    frac    = sum - (wx <<< 7);
    r.rest  = frac[7:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/psa_mac.sv -----
// ----------------------------------------------------------------------------
// psa_mac: shared multiply-accumulate unit
// One 32x17 multiplier and a 49-bit adder, result registered each enabled
// cycle. Every product of the pointer datapath goes through here.
// ----------------------------------------------------------------------------
`default_nettype none

module psa_mac import psa_pkg::*; (
  input  wire logic             clk_i,
  input  wire mac_opnd_t        opnd_i,
  output      logic [MAC_W-1:0] res_o
);

  logic [MAC_W-1:0] prod;
  logic [MAC_W-1:0] res_d, res_q;

  assign prod  = MAC_W'(opnd_i.a) * MAC_W'(opnd_i.b);
  assign res_d = prod + opnd_i.c;

  always_ff @(posedge clk_i) begin
    if (opnd_i.en) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ----- hw/rtl/psa_root.sv -----
// ----------------------------------------------------------------------------
// psa_root: iterative floor square root
// Restoring bit-pair method, one result bit per cycle, 16-bit root of a
// 32-bit radicand.
// ----------------------------------------------------------------------------
`default_nettype none

module psa_root import psa_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [31:0]       val_i,
  output      logic              last_o,
  output      logic [ROOT_W-1:0] root_o
);

  logic [31:0]           rem_d, rem_q;
  logic [31:0]           r_d, r_q;
  logic [31:0]           bit_d, bit_q;
  logic [ROOT_CNT_W-1:0] cnt_d, cnt_q;
  logic [32:0]           trial;

  assign trial = {1'b0, r_q} + {1'b0, bit_q};

  always_comb begin
    rem_d = rem_q;
    r_d   = r_q;
    bit_d = bit_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = val_i;
      r_d   = '0;
      bit_d = 32'h4000_0000;
      cnt_d = ROOT_CNT_W'(ROOT_STEPS);
    end else if (cnt_q != '0) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_d = rem_q - trial[31:0];
        r_d   = (r_q >> 1) + bit_q;
      end else begin
        r_d   = r_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q - ROOT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    r_q   <= r_d;
    bit_q <= bit_d;
  end

  assign last_o = (cnt_q == ROOT_CNT_W'(1));
  assign root_o = r_q[ROOT_W-1:0];

endmodule

`default_nettype wire

// ----- hw/rtl/psa_ctrl.sv -----
// ----------------------------------------------------------------------------
// psa_ctrl: sequencer
// Steps an acceleration report through the shared multiplier and root unit,
// a scroll report straight to its load; then waits for a free output register.
// ----------------------------------------------------------------------------
`default_nettype none

module psa_ctrl import psa_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire psa_stat_t stat_i,
  output      psa_ctrl_t ctrl_o
);

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0_0000_0000_0001,
    ST_SQX    = 13'b0_0000_0000_0010,
    ST_SQY    = 13'b0_0000_0000_0100,
    ST_RSTART = 13'b0_0000_0000_1000,
    ST_RWAIT  = 13'b0_0000_0001_0000,
    ST_FACT   = 13'b0_0000_0010_0000,
    ST_MOM    = 13'b0_0000_0100_0000,
    ST_KEEP   = 13'b0_0000_1000_0000,
    ST_AVG    = 13'b0_0001_0000_0000,
    ST_SCX    = 13'b0_0010_0000_0000,
    ST_SCY    = 13'b0_0100_0000_0000,
    ST_SCROLL = 13'b0_1000_0000_0000,
    ST_DONE   = 13'b1_0000_0000_0000
  } state_e;

  state_e state_d, state_q;

  always_comb begin
    state_d            = state_q;
    ctrl_o             = '0;
    ctrl_o.mac_op      = MAC_HOLD;
    case (state_q)
      ST_IDLE: begin
        ctrl_o.idle = 1'b1;
        if (stat_i.in_accept) begin
          state_d = stat_i.scroll ? ST_SCROLL : ST_SQX;
        end
      end
      ST_SQX: begin
        ctrl_o.mac_op = MAC_SQX;
        state_d       = ST_SQY;
      end
      ST_SQY: begin
        ctrl_o.mac_op = MAC_SQY;
        state_d       = ST_RSTART;
      end
      ST_RSTART: begin
        ctrl_o.root_start = 1'b1;
        state_d           = ST_RWAIT;
      end
      ST_RWAIT: begin
        if (stat_i.root_last) begin
          state_d = ST_FACT;
        end
      end
      ST_FACT: begin
        ctrl_o.mac_op = MAC_FACT;
        state_d       = ST_MOM;
      end
      ST_MOM: begin
        ctrl_o.mac_op = MAC_MOM;
        state_d       = ST_KEEP;
      end
      ST_KEEP: begin
        ctrl_o.mac_op = MAC_KEEP;
        state_d       = ST_AVG;
      end
      ST_AVG: begin
        ctrl_o.avg_load = 1'b1;
        state_d         = ST_SCX;
      end
      ST_SCX: begin
        ctrl_o.mac_op = MAC_SCX;
        state_d       = ST_SCY;
      end
      ST_SCY: begin
        ctrl_o.mac_op = MAC_SCY;
        ctrl_o.x_load = 1'b1;
        state_d       = ST_DONE;
      end
      ST_SCROLL: begin
        ctrl_o.scroll_load = 1'b1;
        state_d            = ST_DONE;
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/pointer_scroll_and_acceleration.sv -----
// ----------------------------------------------------------------------------
// pointer_scroll_and_acceleration: drag-scroll and pointer acceleration
// One mouse report in, one report out. Scroll mode turns movement into
// wheel counts with fractional carry; otherwise movement is scaled by a
// moving-average factor driven by the movement length.
//
//   channel  signals                                    direction
//   in       in_valid_i  in_stall_o  in_data_i          report in
//   out      out_valid_o out_stall_i out_data_o         report out
//   cfg      cfg_we_i    cfg_idx_i   cfg_wdata_i        register write
//
// An acceleration report passes through the 16-step square root and
// seven times through the shared 32x17 multiplier; a scroll report
// uses neither and goes straight to its result register.
// Input is taken only while the sequencer idles; a finished report waits in
// the output register and the next report can be accepted meanwhile.
// Reset restores register defaults, clears remainders, average = 2.0.
// ----------------------------------------------------------------------------
`default_nettype none

module pointer_scroll_and_acceleration import psa_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire psa_in_t               in_data_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      psa_out_t              out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  psa_ctrl_t ctrl;
  psa_stat_t stat;
  mac_opnd_t opnd;

  logic [MAC_W-1:0]  res;
  logic [ROOT_W-1:0] root;
  logic              root_last;

  logic [2:0]  shift_h_q, shift_v_q;
  logic [7:0]  min_q, max_q, growth_q;
  logic [15:0] mom_q;

  logic [7:0]         rest_h_q, rest_v_q;
  logic [MAC_A_W-1:0] avg_q;
  logic [MAC_A_W-1:0] sel_q;
  logic [MAC_A_W-1:0] avg_new;
  logic [MAC_A_W-1:0] cap;

  psa_in_t  item_q;
  psa_out_t rslt_q;
  psa_out_t out_d, out_q;
  logic     out_valid_q;

  logic [8:0]        ax, ay;
  scroll_res_t       scr_h, scr_v;
  logic signed [8:0] neg_h;
  logic              in_accept;
  logic              out_free;

  assign in_accept = in_valid_i && ctrl.idle;
  assign out_free  = !out_valid_q || !out_stall_i;

  assign stat.in_accept = in_accept;
  assign stat.scroll    = in_data_i.scroll_mode;
  assign stat.root_last = root_last;
  assign stat.out_free  = out_free;

  psa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  psa_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl.root_start),
    .val_i   ({res[15:0], 16'h0000}),
    .last_o  (root_last),
    .root_o  (root)
  );

  psa_mac u_mac (
    .clk_i  (clk_i),
    .opnd_i (opnd),
    .res_o  (res)
  );

  assign ax = abs8(item_q.move_x);
  assign ay = abs8(item_q.move_y);

  // operand routing for the shared multiplier
  always_comb begin
    opnd    = '0;
    opnd.en = 1'b1;
    case (ctrl.mac_op)
      MAC_SQX: begin
        opnd.a = MAC_A_W'(ax);
        opnd.b = MAC_B_W'(ax);
      end
      MAC_SQY: begin
        opnd.a = MAC_A_W'(ay);
        opnd.b = MAC_B_W'(ay);
        opnd.c = res;
      end
      MAC_FACT: begin
        // growth*len + min*256; the factor is this times 256
        opnd.a = MAC_A_W'(root);
        opnd.b = MAC_B_W'(growth_q);
        opnd.c = MAC_W'({min_q, 8'h00});
      end
      MAC_MOM: begin
        opnd.a = {res[23:0], 8'h00};
        opnd.b = MAC_B_W'(mom_q);
      end
      MAC_KEEP: begin
        opnd.a = avg_q;
        opnd.b = ONE_Q16 - MAC_B_W'(mom_q);
        opnd.c = res;
      end
      MAC_SCX: begin
        opnd.a = sel_q;
        opnd.b = MAC_B_W'(ax);
      end
      MAC_SCY: begin
        opnd.a = sel_q;
        opnd.b = MAC_B_W'(ay);
      end
      default: begin
        opnd.en = 1'b0;
      end
    endcase
  end

  assign avg_new = res[47:16];
  assign cap     = {8'h00, max_q, 16'h0000};

  assign scr_h = scroll_axis(rest_h_q, item_q.move_x, shift_h_q);
  assign scr_v = scroll_axis(rest_v_q, item_q.move_y, shift_v_q);
  assign neg_h = -scr_h.whole;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_h_q <= SHIFT_RESET;
      shift_v_q <= SHIFT_RESET;
      min_q     <= MIN_RESET;
      max_q     <= MAX_RESET;
      growth_q  <= GROWTH_RESET;
      mom_q     <= MOMENTUM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SHIFT_H:  shift_h_q <= cfg_wdata_i[2:0];
        REG_SHIFT_V:  shift_v_q <= cfg_wdata_i[2:0];
        REG_MIN:      min_q     <= cfg_wdata_i[7:0];
        REG_MAX:      max_q     <= cfg_wdata_i[7:0];
        REG_GROWTH:   growth_q  <= cfg_wdata_i[7:0];
        REG_MOMENTUM: mom_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_h_q <= '0;
      rest_v_q <= '0;
      avg_q    <= AVG_RESET;
    end else begin
      if (ctrl.scroll_load) begin
        rest_h_q <= scr_h.rest;
        rest_v_q <= scr_v.rest;
      end
      if (ctrl.avg_load) begin
        avg_q <= avg_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
    end
    if (ctrl.avg_load) begin
      // strictly above the cap: scale by the cap register instead
      sel_q <= (avg_new > cap) ? cap : avg_new;
    end
    if (ctrl.scroll_load) begin
      rslt_q.out_x       <= '0;
      rslt_q.out_y       <= '0;
      rslt_q.out_wheel_h <= sat9(neg_h);
      rslt_q.out_wheel_v <= sat9(scr_v.whole);
    end
    if (ctrl.x_load) begin
      rslt_q.out_x       <= sat_mag(res[39:16], item_q.move_x[7]);
      rslt_q.out_y       <= '0;
      rslt_q.out_wheel_h <= item_q.wheel_h_in;
      rslt_q.out_wheel_v <= item_q.wheel_v_in;
    end
    if (ctrl.out_load) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    out_d = rslt_q;
    if (!item_q.scroll_mode) begin
      out_d.out_y = sat_mag(res[39:16], item_q.move_y[7]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign in_stall_o  = !ctrl.idle;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- tb/tb_pointer_scroll_and_acceleration.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pointer_scroll_and_acceleration: self-checking testbench
// Feeds mouse reports through the valid/stall channels with random idle
// bursts on both sides, keeps its own copy of the scroll remainders and the
// averaged acceleration factor, predicts every output report and compares
// it field by field in order. Registers are rewritten between phases.
// ----------------------------------------------------------------------------

module tb_pointer_scroll_and_acceleration;
  import psa_pkg::*;

  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 40;
  localparam int MAX_PRINTS     = 50;

  // indexes past the register file; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  psa_in_t               in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  psa_out_t              out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // register copies
  logic [2:0]  shift_h   = SHIFT_RESET;
  logic [2:0]  shift_v   = SHIFT_RESET;
  logic [7:0]  min_gain  = MIN_RESET;
  logic [7:0]  cap_gain  = MAX_RESET;
  logic [7:0]  growth    = GROWTH_RESET;
  logic [15:0] momentum  = MOMENTUM_RESET;

  // block state copies
  logic [7:0]  rest_h  = 8'd0;
  logic [7:0]  rest_v  = 8'd0;
  logic [31:0] avg_q16 = AVG_RESET;

  psa_in_t  pending[$];
  psa_out_t reports_due[$];

  int errors       = 0;
  int send_gap     = 0;
  int sink_gap     = 0;
  int hold_left    = 0;
  int hold_asks    = 0;
  int holds_done   = 0;
  int quiet_cycles = 0;
  bit calm         = 1'b0;

  pointer_scroll_and_acceleration i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) begin
      $display("ERROR: %s", msg);
    end
  endtask

  function automatic logic [7:0] clip8(input longint v);
    if (v > 127) begin
      return 8'h7f;
    end else if (v < -128) begin
      return 8'h80;
    end
    return v[7:0];
  endfunction

  function automatic longint isqrt(input longint v);
    longint root;
    longint probe;
    root  = 0;
    probe = longint'(1) << 32;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // magnitude times the Q16.16 average, truncated toward zero
  function automatic longint scale_by_avg(input longint m);
    longint mag;
    mag = ((m < 0) ? -m : m) * longint'(avg_q16);
    mag = mag >> 16;
    return (m < 0) ? -mag : mag;
  endfunction

  // remainder in 1/128 units, integer part truncated toward zero
  task automatic scroll_step(input logic [7:0] rest, input logic signed [7:0] move,
                             input logic [2:0] shift, output logic [7:0] new_rest,
                             output longint whole);
    longint sum;
    sum      = longint'($signed(rest)) + longint'(move) * (longint'(1) << (3'd7 - shift));
    whole    = sum / 128;
    sum      = sum - whole * 128;
    new_rest = sum[7:0];
  endtask

  task automatic predict_report(input psa_in_t r);
    psa_out_t   o;
    longint     x;
    longint     y;
    longint     whole_h;
    longint     whole_v;
    longint     len;
    longint     factor;
    longint     acc;
    logic [7:0] rest;
    x = longint'($signed(r.move_x));
    y = longint'($signed(r.move_y));
    o.out_wheel_h = r.wheel_h_in;
    o.out_wheel_v = r.wheel_v_in;
    if (r.scroll_mode) begin
      scroll_step(rest_h, r.move_x, shift_h, rest, whole_h);
      rest_h = rest;
      scroll_step(rest_v, r.move_y, shift_v, rest, whole_v);
      rest_v = rest;
      o.out_x       = '0;
      o.out_y       = '0;
      o.out_wheel_h = clip8(-whole_h);
      o.out_wheel_v = clip8(whole_v);
    end else begin
      len     = isqrt((x * x + y * y) << 16);
      factor  = longint'(growth) * len * 256 + (longint'(min_gain) << 16);
      acc     = longint'(avg_q16) * (65536 - longint'(momentum))
              + factor * longint'(momentum);
      avg_q16 = 32'(acc >> 16);
      // strict compare: an average equal to the cap still scales by the average
      if (longint'(avg_q16) > (longint'(cap_gain) << 16)) begin
        o.out_x = clip8(x * longint'(cap_gain));
        o.out_y = clip8(y * longint'(cap_gain));
      end else begin
        o.out_x = clip8(scale_by_avg(x));
        o.out_y = clip8(scale_by_avg(y));
      end
    end
    reports_due.push_back(o);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      REG_SHIFT_H:  shift_h   = value[2:0];
      REG_SHIFT_V:  shift_v   = value[2:0];
      REG_MIN:      min_gain  = value[7:0];
      REG_MAX:      cap_gain  = value[7:0];
      REG_GROWTH:   growth    = value[7:0];
      REG_MOMENTUM: momentum  = value;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending.size() != 0 || reports_due.size() != 0) @(negedge clk_i);
  endtask

  function automatic psa_in_t mk_report(input int x, input int y, input int wh,
                                        input int wv, input bit scroll);
    psa_in_t r;
    r.move_x      = x[7:0];
    r.move_y      = y[7:0];
    r.wheel_h_in  = wh[7:0];
    r.wheel_v_in  = wv[7:0];
    r.scroll_mode = scroll;
    return r;
  endfunction

  // random word; the register's own bits are forced to an extreme now and then
  function automatic logic [15:0] rand_word(input logic [15:0] field);
    logic [15:0] w;
    w = 16'($urandom);
    case ($urandom_range(0, 3))
      0: w = w & ~field;
      1: w = w | field;
      default: ;
    endcase
    return w;
  endfunction

  task automatic run_random_phase(input int count, input bit long_hold);
    psa_in_t r;
    bit      mode;
    write_reg(REG_SHIFT_H, rand_word(16'h0007));
    write_reg(REG_SHIFT_V, rand_word(16'h0007));
    write_reg(REG_MIN, rand_word(16'h00ff));
    write_reg(REG_MAX, rand_word(16'h00ff));
    write_reg(REG_GROWTH, rand_word(16'h00ff));
    write_reg(REG_MOMENTUM, rand_word(16'hffff));
    write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_6 : REG_SPARE_7, 16'($urandom));
    if (long_hold) begin
      hold_asks++;
    end
    mode = $urandom_range(0, 1);
    for (int n = 0; n < count; n++) begin
      // modes come in runs so remainders and the average build up
      if ($urandom_range(0, 3) == 0) begin
        mode = ~mode;
      end
      r.move_x      = 8'($urandom);
      r.move_y      = 8'($urandom);
      r.wheel_h_in  = 8'($urandom);
      r.wheel_v_in  = 8'($urandom);
      r.scroll_mode = mode;
      if ($urandom_range(0, 2) == 0) begin
        r.move_x = 8'($urandom_range(0, 16) - 8);
        r.move_y = 8'($urandom_range(0, 16) - 8);
      end
      pending.push_back(r);
    end
  endtask

  // stimulus
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // frozen average of 2.0 against caps of 2, 1 and 0
    write_reg(REG_MOMENTUM, 16'd0);
    write_reg(REG_MAX, 16'd2);
    pending.push_back(mk_report(3, -3, 127, -128, 1'b0));
    pending.push_back(mk_report(127, -128, -128, 127, 1'b0));
    pending.push_back(mk_report(0, 0, 0, 0, 1'b0));
    pending.push_back(mk_report(127, -128, 55, -55, 1'b1));
    pending.push_back(mk_report(-128, 127, -1, 1, 1'b1));
    pending.push_back(mk_report(1, -1, 0, 0, 1'b1));
    pending.push_back(mk_report(1, -1, 0, 0, 1'b1));
    wait_drained();
    write_reg(REG_MAX, 16'd1);
    pending.push_back(mk_report(-5, 7, 9, -9, 1'b0));
    pending.push_back(mk_report(-128, 127, 0, 0, 1'b0));
    wait_drained();
    write_reg(REG_MAX, 16'd0);
    pending.push_back(mk_report(100, -100, 1, 2, 1'b0));
    wait_drained();

    // scroll divisors at both ends; wheel saturation on negation
    write_reg(REG_SHIFT_H, 16'hfff8);
    write_reg(REG_SHIFT_V, 16'h0007);
    write_reg(REG_SPARE_6, 16'hffff);
    write_reg(REG_SPARE_7, 16'hffff);
    pending.push_back(mk_report(-128, 127, 127, 127, 1'b1));
    pending.push_back(mk_report(127, -128, -128, -128, 1'b1));
    pending.push_back(mk_report(-1, 1, 0, 0, 1'b1));
    pending.push_back(mk_report(0, 0, -1, -1, 1'b1));
    wait_drained();

    // acceleration at full gain, then decaying toward zero
    write_reg(REG_MOMENTUM, 16'hffff);
    write_reg(REG_GROWTH, 16'hff00 | 16'd255);
    write_reg(REG_MIN, 16'd255);
    write_reg(REG_MAX, 16'd255);
    pending.push_back(mk_report(127, 127, 0, 0, 1'b0));
    pending.push_back(mk_report(-128, -128, 0, 0, 1'b0));
    pending.push_back(mk_report(1, -1, 0, 0, 1'b0));
    pending.push_back(mk_report(0, 0, 0, 0, 1'b0));
    wait_drained();
    write_reg(REG_GROWTH, 16'd0);
    write_reg(REG_MIN, 16'd0);
    write_reg(REG_MOMENTUM, 16'd32768);
    pending.push_back(mk_report(0, 0, 0, 0, 1'b0));
    pending.push_back(mk_report(0, 0, 0, 0, 1'b0));
    pending.push_back(mk_report(-1, 1, 0, 0, 1'b0));
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      run_random_phase(110, p == 2);
      wait_drained();
    end
    calm = 1'b1;
    run_random_phase(60, 1'b0);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // input side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_report(in_data_i);
        void'(pending.pop_front());
      end
      if (in_valid_i && in_stall_o) begin
        // stalled transaction stays on the bus
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        send_gap = $urandom_range(0, 9);
        in_valid_i <= 1'b0;
      end else if (pending.size() != 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output side
  always @(posedge clk_i or negedge rst_ni) begin : sink_side
    psa_out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (reports_due.size() == 0) begin
          flag_error($sformatf("unexpected output report %h", out_data_o));
        end else begin
          want = reports_due.pop_front();
          if (out_data_o.out_x !== want.out_x) begin
            flag_error($sformatf("out_x expected %0d got %0d", want.out_x, out_data_o.out_x));
          end
          if (out_data_o.out_y !== want.out_y) begin
            flag_error($sformatf("out_y expected %0d got %0d", want.out_y, out_data_o.out_y));
          end
          if (out_data_o.out_wheel_h !== want.out_wheel_h) begin
            flag_error($sformatf("out_wheel_h expected %0d got %0d",
                                 want.out_wheel_h, out_data_o.out_wheel_h));
          end
          if (out_data_o.out_wheel_v !== want.out_wheel_v) begin
            flag_error($sformatf("out_wheel_v expected %0d got %0d",
                                 want.out_wheel_v, out_data_o.out_wheel_v));
          end
        end
      end
      if (holds_done != hold_asks) begin
        holds_done++;
        hold_left = LONG_HOLD;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        sink_gap = $urandom_range(0, 9);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
